FILE: rtl/multi_queue_ring_fifo_macros.svh
// Assertion macros shared by the multi-queue ring FIFO modules.
// No dependencies; included by the files that carry assertions.
`ifndef MULTI_QUEUE_RING_FIFO_MACROS_SVH
`define MULTI_QUEUE_RING_FIFO_MACROS_SVH

`ifndef SYNTH
// Check cons in the same cycle as ante.
`define MQRF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check cons in the cycle after ante.
`define MQRF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MQRF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define MQRF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/mqrf_pkg.sv
// Package for the multi-queue ring FIFO: field widths, operation codes
// and the structs passed between the front and back parts. No dependencies.
`default_nettype none

package mqrf_pkg;

  localparam int MODE_W  = 2;
  localparam int QID_W   = 4;
  localparam int VALUE_W = 32;

  // Result queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_PEEK = 2'd2,
    MODE_NONE = 2'd3
  } mqrf_mode_t;

  typedef struct packed {
    logic                      done_res;
    logic                      was_full;
    logic                      was_empty;
    logic signed [VALUE_W-1:0] head_value;
  } mqrf_res_t;

  // Free space in the result queue, as seen by the front
  typedef struct packed {
    logic one;
    logic two;
  } mqrf_room_t;

endpackage

`default_nettype wire

FILE: rtl/mqrf_in_if.sv
// Request channel of the multi-queue ring FIFO: valid/ready plus one item.
// Depends on mqrf_pkg.
`default_nettype none

interface mqrf_in_if import mqrf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [QID_W-1:0]          queue_id;
  logic signed [VALUE_W-1:0] push_value;

  modport source (output valid, output mode, output queue_id, output push_value,
                  input ready);
  modport sink   (input valid, input mode, input queue_id, input push_value,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/mqrf_out_if.sv
// Result channel of the multi-queue ring FIFO: valid/ready plus one item.
// Depends on mqrf_pkg.
`default_nettype none

interface mqrf_out_if import mqrf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      done_res;
  logic                      was_full;
  logic                      was_empty;
  logic signed [VALUE_W-1:0] head_value;

  modport source (output valid, output done_res, output was_full, output was_empty,
                  output head_value, input ready);
  modport sink   (input valid, input done_res, input was_full, input was_empty,
                  input head_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/mqrf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module mqrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mqrf_front.sv
// Front part: accepts items, classifies them against the per-queue
// pointers, updates pointers and drives the element store.
// Depends on mqrf_pkg, mqrf_in_if, mqrf_ram and the assertion macros.
`default_nettype none
`include "multi_queue_ring_fifo_macros.svh"

module mqrf_front import mqrf_pkg::*; #(
  parameter int QUEUE_COUNT = 8,
  parameter int QUEUE_SLOTS = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic       clk,
  input  logic       rst,
  mqrf_in_if.sink    req,
  input  mqrf_room_t room,
  output logic       res_valid,
  output mqrf_res_t  res
);

  localparam int QW     = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int PW     = $clog2(QUEUE_SLOTS);
  localparam int FW     = $clog2(QUEUE_SLOTS + 1);
  localparam int DEPTH  = QUEUE_COUNT * QUEUE_SLOTS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KEEP_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam logic [PW-1:0]    LAST_SLOT = PW'(QUEUE_SLOTS - 1);
  localparam logic [FW-1:0]    FILL_MAX  = FW'(QUEUE_SLOTS);
  localparam logic [QID_W:0]   QCOUNT_V  = (QID_W + 1)'(QUEUE_COUNT);

  // Per-queue pointers and count of slots ever written
  logic [PW-1:0] front_ptr [QUEUE_COUNT];
  logic [PW-1:0] rear_ptr  [QUEUE_COUNT];
  logic [FW-1:0] fill      [QUEUE_COUNT];

  logic              accept;
  logic              id_ok;
  logic [QW-1:0]     qidx;
  logic [PW-1:0]     f;
  logic [PW-1:0]     r;
  logic [FW-1:0]     fl;
  logic [PW-1:0]     f_nxt;
  logic [PW-1:0]     r_nxt;
  logic              full;
  logic              empty;
  logic              done;
  logic              do_push;
  logic              do_pop;
  logic              do_peek;
  logic [AW-1:0]     base;
  logic              we;
  logic              re;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [KEEP_W-1:0] wdata;
  logic [KEEP_W-1:0] rdata;

  // Stage after the store read
  logic s1_valid;
  logic s1_done;
  logic s1_full;
  logic s1_empty;
  logic s1_rd;

  function automatic logic [PW-1:0] slot_after(input logic [PW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  // Pushes fill slots 1, 2, ... and wrap to 0, so the count tells which hold data
  function automatic logic slot_written(input logic [PW-1:0] p, input logic [FW-1:0] n);
    return (p == '0) ? (n == FILL_MAX) : (FW'(p) <= n);
  endfunction

  // Accept only when the result queue can take this item and the one in flight
  assign req.ready = s1_valid ? room.two : room.one;
  assign accept    = req.valid && req.ready;

  // Look up the named queue
  assign id_ok = {1'b0, req.queue_id} < QCOUNT_V;
  assign qidx  = req.queue_id[QW-1:0];
  assign f     = front_ptr[qidx];
  assign r     = rear_ptr[qidx];
  assign fl    = fill[qidx];
  assign f_nxt = slot_after(f);
  assign r_nxt = slot_after(r);
  assign full  = id_ok && (r_nxt == f);
  assign empty = id_ok && (r == f);

  // Classify the operation
  always_comb begin
    do_push = 1'b0;
    do_pop  = 1'b0;
    do_peek = 1'b0;
    case (mqrf_mode_t'(req.mode))
      MODE_PUSH: do_push = id_ok && !full;
      MODE_POP:  do_pop  = id_ok && !empty;
      MODE_PEEK: do_peek = id_ok;
      default: begin
        do_push = 1'b0;
      end
    endcase
  end
  assign done = do_push || do_pop || do_peek;

  // Store access: write the new rear on push, read the slot after front on peek
  assign base  = AW'(int'(qidx) * QUEUE_SLOTS);
  assign we    = accept && do_push;
  assign re    = accept && do_peek;
  assign waddr = base + AW'(r_nxt);
  assign raddr = base + AW'(f_nxt);
  assign wdata = req.push_value[KEEP_W-1:0];

  mqrf_ram #(
    .WIDTH (KEEP_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Advance pointers and capture the classification
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        front_ptr[i] <= '0;
        rear_ptr[i]  <= '0;
        fill[i]      <= '0;
      end
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept && do_push) begin
        rear_ptr[qidx] <= r_nxt;
        fill[qidx]     <= (fl == FILL_MAX) ? fl : fl + 1'b1;
      end
      if (accept && do_pop) begin
        front_ptr[qidx] <= f_nxt;
      end
    end
  end

  // Result flags travel with the store read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_done  <= done;
      s1_full  <= full;
      s1_empty <= empty;
      s1_rd    <= do_peek && slot_written(f_nxt, fl);
    end
  end

  // Form the result; a slot never written reads as zero
  assign res_valid      = s1_valid;
  assign res.done_res   = s1_done;
  assign res.was_full   = s1_full;
  assign res.was_empty  = s1_empty;
  assign res.head_value = s1_rd ? VALUE_W'(rdata) : '0;

  `MQRF_ASSERT_NXT(a_accept_gives_result, clk, rst, accept, res_valid, "accepted item produced no result")
  `MQRF_ASSERT_IMP(a_not_full_and_empty, clk, rst, res_valid, !(res.was_full && res.was_empty), "queue reported full and empty")
  `MQRF_ASSERT_IMP(a_head_needs_done, clk, rst, res_valid && (res.head_value != '0), res.done_res, "head value on operation not done")

endmodule

`default_nettype wire

FILE: rtl/mqrf_back.sv
// Back part: short result queue that decouples the front from the
// receiver and drives the result channel. Depends on mqrf_pkg, mqrf_out_if and the assertion macros.
`default_nettype none
`include "multi_queue_ring_fifo_macros.svh"

module mqrf_back import mqrf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       res_valid,
  input  mqrf_res_t  res,
  output mqrf_room_t room,
  mqrf_out_if.source rsp
);

  mqrf_res_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push = res_valid;
  assign pop  = rsp.valid && rsp.ready;

  // Report space to the front
  assign room.one = count <= QCNT_W'(QDEPTH - 1);
  assign room.two = count <= QCNT_W'(QDEPTH - 2);

  // Hold results in order
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Drive the oldest result
  assign rsp.valid      = count != '0;
  assign rsp.done_res   = slots[rd_ptr].done_res;
  assign rsp.was_full   = slots[rd_ptr].was_full;
  assign rsp.was_empty  = slots[rd_ptr].was_empty;
  assign rsp.head_value = slots[rd_ptr].head_value;

  `MQRF_ASSERT_IMP(a_no_overflow, clk, rst, push && !pop, count < QCNT_W'(QDEPTH), "result queue overflow")
  `MQRF_ASSERT_NXT(a_count_rises, clk, rst, push && !pop, count == $past(count) + 1'b1, "result count did not advance")

endmodule

`default_nettype wire

FILE: rtl/multi_queue_ring_fifo.sv
// Multi-queue ring FIFO: QUEUE_COUNT circular queues in one shared store.
// Channels: req carries one item (mode, queue_id, push_value); rsp carries
//   one result per item (done_res, was_full, was_empty, head_value).
// Path: an accepted item is registered with the store read in the front,
//   then held in the result queue in the back until the receiver takes it.
// Throughput: one item per cycle while req.ready is high; the per-queue pointer
//   read-modify-write and one store access (write on push, read on peek) share the accept cycle.
// Reset: all front/rear pointers clear; per-queue fill counts clear, so
//   slots never written read as zero with no clearing pass over the store.
// Receiver stall: results wait in a four-entry queue; req.ready drops when
//   that queue cannot take the item in flight plus a new one.
// Depends on mqrf_pkg, mqrf_in_if, mqrf_out_if, mqrf_front, mqrf_back.
`default_nettype none

module multi_queue_ring_fifo import mqrf_pkg::*; #(
  parameter int QUEUE_COUNT = 8,
  parameter int QUEUE_SLOTS = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic       clk,
  input  logic       rst,
  mqrf_in_if.sink    req,
  mqrf_out_if.source rsp
);

  logic       res_valid;
  mqrf_res_t  res;
  mqrf_room_t room;

  mqrf_front #(
    .QUEUE_COUNT (QUEUE_COUNT),
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .room      (room),
    .res_valid (res_valid),
    .res       (res)
  );

  mqrf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .room      (room),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
